@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Both take a label, a property and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPC_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPC_ASSERT(lbl, prop, msg)
`define TPC_ASSERT_NR(lbl, prop, msg)
`endif
`endif

@@ src/tpc_pkg.sv @@
package tpc_pkg;

  localparam int CFG_IDX_WIDTH = 3;
  localparam int EPS_WIDTH     = 31;
  localparam int COLOR_WIDTH   = 32;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_NORMAL_X = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_NORMAL_Y = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_NORMAL_Z = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PLANE_X  = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PLANE_Y  = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PLANE_Z  = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_EPSILON  = 3'd6;

  // Number of vertices on the inside of the plane.
  localparam logic [1:0] NIN_NONE = 2'd0;
  localparam logic [1:0] NIN_ONE  = 2'd1;
  localparam logic [1:0] NIN_TWO  = 2'd2;
  localparam logic [1:0] NIN_ALL  = 2'd3;

  // Vertex selection for one triangle: inside count, the kept inside vertices
  // and the (from, to) vertex pair of each of the two crossings.
  typedef struct packed {
    logic [1:0] nin;
    logic [1:0] ia;
    logic [1:0] ib;
    logic [1:0] f1;
    logic [1:0] t1;
    logic [1:0] f2;
    logic [1:0] t2;
  } sel_t;

  function automatic sel_t classify(input logic [2:0] in_mask);
    sel_t s;
    s = '0;
    case (in_mask)
      3'b000: s.nin = NIN_NONE;
      3'b001: begin
        s.nin = NIN_ONE; s.ia = 2'd0; s.f1 = 2'd0; s.f2 = 2'd0; s.t1 = 2'd1; s.t2 = 2'd2;
      end
      3'b010: begin
        s.nin = NIN_ONE; s.ia = 2'd1; s.f1 = 2'd1; s.f2 = 2'd1; s.t1 = 2'd0; s.t2 = 2'd2;
      end
      3'b100: begin
        s.nin = NIN_ONE; s.ia = 2'd2; s.f1 = 2'd2; s.f2 = 2'd2; s.t1 = 2'd0; s.t2 = 2'd1;
      end
      3'b011: begin
        s.nin = NIN_TWO; s.ia = 2'd0; s.ib = 2'd1; s.f1 = 2'd0; s.f2 = 2'd1;
        s.t1 = 2'd2; s.t2 = 2'd2;
      end
      3'b101: begin
        s.nin = NIN_TWO; s.ia = 2'd0; s.ib = 2'd2; s.f1 = 2'd0; s.f2 = 2'd2;
        s.t1 = 2'd1; s.t2 = 2'd1;
      end
      3'b110: begin
        s.nin = NIN_TWO; s.ia = 2'd1; s.ib = 2'd2; s.f1 = 2'd1; s.f2 = 2'd2;
        s.t1 = 2'd0; s.t2 = 2'd0;
      end
      default: s.nin = NIN_ALL;
    endcase
    return s;
  endfunction

endpackage

@@ src/tpc_if.sv @@
interface tpc_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] v0_x, v0_y, v0_z;
  logic signed [COORD_WIDTH-1:0] v1_x, v1_y, v1_z;
  logic signed [COORD_WIDTH-1:0] v2_x, v2_y, v2_z;
  logic [31:0]                   tri_color;

  modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  tri_color, input ready);
  modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                tri_color, output ready);
endinterface

interface tpc_out_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_x, a_y, a_z;
  logic signed [COORD_WIDTH-1:0] b_x, b_y, b_z;
  logic signed [COORD_WIDTH-1:0] c_x, c_y, c_z;
  logic [31:0]                   out_color;
  logic                          last;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  out_color, last, input ready);
  modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                out_color, last, output ready);
endinterface

@@ src/triangle_plane_clipper.sv @@
// Triangle clipper against one plane.
// in_tri carries one triangle request (three vertices and a colour) with a
// valid/ready handshake; out_tri returns zero, one or two triangles per request,
// with last set on the final triangle of each request. A request that lies wholly
// outside the plane produces nothing. The plane (normal, point) and epsilon are
// written through cfg_we/cfg_idx/cfg_data; they must be written only while no
// request is in flight, which the block itself does not enforce. A request
// passes four stages that form the distances and the crossing denominators,
// one stage per quotient bit of the restoring divider, one multiply stage and
// one interpolation stage before the output register. One request enters per
// cycle while the pipeline is not stalled; a request that splits into two
// triangles holds the output register for both of them, so split requests
// lower the sustained rate, which is set by the single output register.
// Reset is synchronous: the pipeline empties and the registers return to
// normal (0, 0, 1.0), point (0, 0, 0) and epsilon of one lsb. When the receiver
// stalls, the whole pipeline holds and in_tri.ready falls once the last stage
// holds a request with a triangle to emit; nothing is dropped or repeated.
`include "assert_macros.svh"

module triangle_plane_clipper #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int CFG_WIDTH  = (COORD_WIDTH > tpc_pkg::EPS_WIDTH) ? COORD_WIDTH
                                                                 : tpc_pkg::EPS_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  tpc_in_if.sink                             in_tri,
  tpc_out_if.source                          out_tri,
  input  logic                               cfg_we,
  input  logic [tpc_pkg::CFG_IDX_WIDTH-1:0]  cfg_idx,
  input  logic [CFG_WIDTH-1:0]               cfg_data
);
  import tpc_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int PW = 2 * W;
  localparam int D  = 2 * W + 3;
  localparam int MW = 2 * W + 1;
  localparam int EW = (D > EPS_WIDTH + FRAC_BITS) ? D : EPS_WIDTH + FRAC_BITS;

  typedef logic [2:0][W-1:0]       vtx_t;
  typedef logic [2:0][2:0][W-1:0]  tri_t;

  typedef struct packed {
    logic [D-1:0] den;
    logic [D-1:0] rem;
    logic [W-1:0] quo;
    logic         kz;
  } lane_t;

  typedef struct packed {
    tri_t                   vt;
    logic [COLOR_WIDTH-1:0] color;
    sel_t                   sel;
    lane_t [1:0]            ln;
  } item_t;

  function automatic vtx_t pick_v(input tri_t t, input logic [1:0] i);
    case (i)
      2'd0:    return t[0];
      2'd1:    return t[1];
      default: return t[2];
    endcase
  endfunction

  function automatic logic [D-1:0] pick_d(input logic [D-1:0] d0, input logic [D-1:0] d1,
                                          input logic [D-1:0] d2, input logic [1:0] i);
    case (i)
      2'd0:    return d0;
      2'd1:    return d1;
      default: return d2;
    endcase
  endfunction

  // Configuration registers
  logic [W-1:0]         nrm_r [3];
  logic [W-1:0]         pnt_r [3];
  logic [EPS_WIDTH-1:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r[0] <= '0;
      nrm_r[1] <= '0;
      nrm_r[2] <= W'(1) << FRAC_BITS;
      pnt_r[0] <= '0;
      pnt_r[1] <= '0;
      pnt_r[2] <= '0;
      eps_r    <= EPS_WIDTH'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_NORMAL_X: nrm_r[0] <= cfg_data[W-1:0];
        REG_NORMAL_Y: nrm_r[1] <= cfg_data[W-1:0];
        REG_NORMAL_Z: nrm_r[2] <= cfg_data[W-1:0];
        REG_PLANE_X:  pnt_r[0] <= cfg_data[W-1:0];
        REG_PLANE_Y:  pnt_r[1] <= cfg_data[W-1:0];
        REG_PLANE_Z:  pnt_r[2] <= cfg_data[W-1:0];
        REG_EPSILON:  eps_r    <= cfg_data[EPS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: every stage moves together when the last stage is empty or can hand on its request.
  logic adv;
  logic l_take;

  tri_t vin;
  always_comb begin
    vin[0] = {in_tri.v0_z, in_tri.v0_y, in_tri.v0_x};
    vin[1] = {in_tri.v1_z, in_tri.v1_y, in_tri.v1_x};
    vin[2] = {in_tri.v2_z, in_tri.v2_y, in_tri.v2_x};
  end

  assign in_tri.ready = adv;

  // Stage 1: products
  logic                   s1_v_r, s2_v_r, s3_v_r;
  tri_t                   s1_vt_r, s2_vt_r, s3_vt_r;
  logic [COLOR_WIDTH-1:0] s1_col_r, s2_col_r, s3_col_r;
  logic signed [PW-1:0]   s1_pv_r [3][3];
  logic signed [PW-1:0]   s1_pp_r [3];
  logic signed [D-1:0]    s2_sv_r [3];
  logic signed [D-1:0]    s2_sp_r;
  logic signed [D-1:0]    s3_d_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_vt_r  <= vin;
      s1_col_r <= in_tri.tri_color;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s1_pv_r[i][j] <= $signed(vin[i][j]) * $signed(nrm_r[j]);
        end
        s1_pp_r[i] <= $signed(pnt_r[i]) * $signed(nrm_r[i]);
      end
      // Stage 2: per-vertex sums and the plane offset
      s2_vt_r  <= s1_vt_r;
      s2_col_r <= s1_col_r;
      for (int i = 0; i < 3; i++) begin
        s2_sv_r[i] <= D'(s1_pv_r[i][0]) + D'(s1_pv_r[i][1]) + D'(s1_pv_r[i][2]);
      end
      s2_sp_r <= D'(s1_pp_r[0]) + D'(s1_pp_r[1]) + D'(s1_pp_r[2]);
      // Stage 3: signed distances
      s3_vt_r  <= s2_vt_r;
      s3_col_r <= s2_col_r;
      for (int i = 0; i < 3; i++) begin
        s3_d_r[i] <= s2_sv_r[i] - s2_sp_r;
      end
    end
  end

  // Stage 4: classification and crossing set-up, then one quotient bit per stage.
  item_t pipe_r [W+1];
  logic  pv_r   [W+1];
  item_t s4_nxt;

  always_comb begin
    logic [2:0]   in_mask;
    logic [D-1:0] df, dt, den;
    logic [1:0]   fi, ti;
    for (int i = 0; i < 3; i++) begin
      in_mask[i] = !s3_d_r[i][D-1];
    end
    s4_nxt       = '0;
    s4_nxt.vt    = s3_vt_r;
    s4_nxt.color = s3_col_r;
    s4_nxt.sel   = classify(in_mask);
    for (int l = 0; l < 2; l++) begin
      fi  = (l == 0) ? s4_nxt.sel.f1 : s4_nxt.sel.f2;
      ti  = (l == 0) ? s4_nxt.sel.t1 : s4_nxt.sel.t2;
      df  = pick_d(s3_d_r[0], s3_d_r[1], s3_d_r[2], fi);
      dt  = pick_d(s3_d_r[0], s3_d_r[1], s3_d_r[2], ti);
      den = df - dt;
      s4_nxt.ln[l].den = den;
      s4_nxt.ln[l].rem = df;
      s4_nxt.ln[l].quo = '0;
      s4_nxt.ln[l].kz  = EW'(den) <= EW'({eps_r, {FRAC_BITS{1'b0}}});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r[0] <= s4_nxt;
    end
  end

  for (genvar s = 0; s < W; s++) begin : g_div
    item_t stg_nxt;

    // Restoring division: on a crossing lane the remainder stays below the denominator.
    always_comb begin
      logic [D:0] r2;
      logic [D:0] dif;
      logic       ge;
      stg_nxt = pipe_r[s];
      for (int l = 0; l < 2; l++) begin
        r2  = {pipe_r[s].ln[l].rem, 1'b0};
        ge  = r2 >= {1'b0, pipe_r[s].ln[l].den};
        dif = r2 - {1'b0, pipe_r[s].ln[l].den};
        stg_nxt.ln[l].rem = ge ? dif[D-1:0] : r2[D-1:0];
        stg_nxt.ln[l].quo = {pipe_r[s].ln[l].quo[W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pipe_r[s+1] <= stg_nxt;
      end
    end
  end

  // Multiply stage: |t - f| * k for each component of both crossings.
  logic          m_v_r;
  item_t         m_item_r;
  logic [MW-1:0] m_prod_r [2][3];
  logic          m_neg_r  [2][3];

  always_ff @(posedge clk) begin
    logic [W-1:0] k;
    vtx_t         fv, tv;
    logic [W:0]   delta, magd;
    if (adv) begin
      m_item_r <= pipe_r[W];
      for (int l = 0; l < 2; l++) begin
        k  = pipe_r[W].ln[l].kz ? '0 : pipe_r[W].ln[l].quo;
        fv = pick_v(pipe_r[W].vt, (l == 0) ? pipe_r[W].sel.f1 : pipe_r[W].sel.f2);
        tv = pick_v(pipe_r[W].vt, (l == 0) ? pipe_r[W].sel.t1 : pipe_r[W].sel.t2);
        for (int c = 0; c < 3; c++) begin
          delta = {tv[c][W-1], tv[c]} - {fv[c][W-1], fv[c]};
          magd  = delta[W] ? -delta : delta;
          m_neg_r[l][c]  <= delta[W];
          m_prod_r[l][c] <= MW'(magd) * MW'(k);
        end
      end
    end
  end

  // Interpolation stage: crossing points and the output triangles.
  logic                   l_v_r;
  tri_t                   l_tri0_r, l_tri1_r;
  logic [COLOR_WIDTH-1:0] l_col_r;
  logic [1:0]             l_nin_r;
  tri_t                   l_tri0_nxt, l_tri1_nxt;

  always_comb begin
    vtx_t       fv;
    vtx_t       xp [2];
    logic [W:0] qq, off;
    for (int l = 0; l < 2; l++) begin
      fv = pick_v(m_item_r.vt, (l == 0) ? m_item_r.sel.f1 : m_item_r.sel.f2);
      for (int c = 0; c < 3; c++) begin
        // A negative step rounds towards minus infinity.
        qq  = m_prod_r[l][c][MW-1:W] + (W+1)'(|m_prod_r[l][c][W-1:0]);
        off = m_neg_r[l][c] ? (m_prod_r[l][c][MW-1:W] == '0 && !(|m_prod_r[l][c][W-1:0])
                               ? '0 : -qq)
                            : m_prod_r[l][c][MW-1:W];
        xp[l][c] = fv[c] + off[W-1:0];
      end
    end
    l_tri1_nxt = '0;
    case (m_item_r.sel.nin)
      NIN_ONE: begin
        l_tri0_nxt = {xp[1], xp[0], pick_v(m_item_r.vt, m_item_r.sel.ia)};
      end
      NIN_TWO: begin
        l_tri0_nxt = {pick_v(m_item_r.vt, m_item_r.sel.ib), xp[0],
                      pick_v(m_item_r.vt, m_item_r.sel.ia)};
        l_tri1_nxt = {pick_v(m_item_r.vt, m_item_r.sel.ib), xp[1], xp[0]};
      end
      default: l_tri0_nxt = m_item_r.vt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_tri0_r <= l_tri0_nxt;
      l_tri1_r <= l_tri1_nxt;
      l_col_r  <= m_item_r.color;
      l_nin_r  <= m_item_r.sel.nin;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      for (int s = 0; s <= W; s++) begin
        pv_r[s] <= 1'b0;
      end
      m_v_r <= 1'b0;
      l_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= in_tri.valid;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      pv_r[0] <= s3_v_r;
      for (int s = 0; s < W; s++) begin
        pv_r[s+1] <= pv_r[s];
      end
      m_v_r <= pv_r[W];
      l_v_r <= m_v_r;
    end
  end

  // Output register with a slot for the second triangle of a split request.
  logic                   out_valid_r, out_valid_nxt;
  logic                   pend_r, pend_nxt;
  tri_t                   out_tri_r, sec_r;
  logic [COLOR_WIDTH-1:0] out_col_r;
  logic                   out_last_r;
  logic                   out_free, load_sec, load_l;

  assign out_free = !out_valid_r || out_tri.ready;
  assign load_sec = out_free && pend_r;
  assign load_l   = out_free && !pend_r && l_v_r && (l_nin_r != NIN_NONE);
  assign l_take   = l_v_r && ((l_nin_r == NIN_NONE) || (out_free && !pend_r));
  assign adv      = !l_v_r || l_take;

  always_comb begin
    out_valid_nxt = out_free ? (load_sec || load_l) : out_valid_r;
    if (load_sec) begin
      pend_nxt = 1'b0;
    end else if (load_l) begin
      pend_nxt = (l_nin_r == NIN_TWO);
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sec) begin
      out_tri_r  <= sec_r;
      out_last_r <= 1'b1;
    end else if (load_l) begin
      out_tri_r  <= l_tri0_r;
      out_last_r <= (l_nin_r != NIN_TWO);
      out_col_r  <= l_col_r;
      sec_r      <= l_tri1_r;
    end
  end

  assign out_tri.valid     = out_valid_r;
  assign out_tri.a_x       = out_tri_r[0][0];
  assign out_tri.a_y       = out_tri_r[0][1];
  assign out_tri.a_z       = out_tri_r[0][2];
  assign out_tri.b_x       = out_tri_r[1][0];
  assign out_tri.b_y       = out_tri_r[1][1];
  assign out_tri.b_z       = out_tri_r[1][2];
  assign out_tri.c_x       = out_tri_r[2][0];
  assign out_tri.c_y       = out_tri_r[2][1];
  assign out_tri.c_z       = out_tri_r[2][2];
  assign out_tri.out_color = out_col_r;
  assign out_tri.last      = out_last_r;

  `TPC_ASSERT(a_pend_shown, pend_r |-> out_valid_r, "second triangle pending without a shown first")
  `TPC_ASSERT(a_pend_first, pend_r |-> !out_last_r, "first of a pair marked as last")
  `TPC_ASSERT(a_l_hold, (l_v_r && !l_take) |=> (l_v_r && $stable(l_nin_r)), "stalled stage lost")
  `TPC_ASSERT_NR(a_rst_idle, !rst_n |=> !out_valid_r && !pend_r, "output not idle after reset")

endmodule
